@@ design/psm_pkg.sv @@
// Shared constants, types and register codes for the pulse sequence matcher.
// No dependencies; every other file imports this package.
package psm_pkg;

  localparam int WINDOW    = 5;
  localparam int PULSE_W   = 20;
  localparam int TOL_W     = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = PULSE_W;
  localparam int FILL_W    = $clog2(WINDOW + 1);

  typedef logic [PULSE_W-1:0] pulse_t;
  typedef logic [TOL_W-1:0]   tol_t;

  localparam logic [CFG_IDX_W-1:0] REG_TOL_BELOW = CFG_IDX_W'(WINDOW);
  localparam logic [CFG_IDX_W-1:0] REG_TOL_ABOVE = CFG_IDX_W'(WINDOW + 1);

  localparam pulse_t TARGET_INIT [WINDOW] = '{
    PULSE_W'(2675), PULSE_W'(2000), PULSE_W'(3000), PULSE_W'(4000), PULSE_W'(5000)
  };
  localparam tol_t TOL_BELOW_INIT = TOL_W'(100);
  localparam tol_t TOL_ABOVE_INIT = TOL_W'(200);

  typedef struct packed {
    logic   shift;
    logic   target_we;
    pulse_t target_wdata;
    tol_t   tol_below;
    tol_t   tol_above;
  } psm_cell_ctrl_t;

endpackage

@@ design/psm_if.sv @@
// Valid/ready channel interfaces for pulse requests, results and register writes.
// Depends on psm_pkg.
interface psm_pulse_if;
  import psm_pkg::*;
  logic   valid;
  logic   ready;
  pulse_t pulse_us;
  modport source (output valid, output pulse_us, input ready);
  modport sink   (input valid, input pulse_us, output ready);
endinterface

interface psm_result_if;
  logic valid;
  logic ready;
  logic accepted;
  logic match;
  modport source (output valid, output accepted, output match, input ready);
  modport sink   (input valid, input accepted, input match, output ready);
endinterface

interface psm_cfg_if;
  import psm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/psm_cell.sv @@
// One window cell: holds a window entry and its target, checks the entering width.
// Depends on psm_pkg.
module psm_cell
  import psm_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  psm_cell_ctrl_t ctrl,
  input  pulse_t         target_init,
  input  pulse_t         data_in,
  output pulse_t         data_out,
  output logic           hit
);

  pulse_t entry;
  pulse_t target;
  logic signed [PULSE_W:0] diff;
  logic signed [PULSE_W:0] low_bound;
  logic signed [PULSE_W:0] high_bound;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry  <= '0;
      target <= target_init;
    end else begin
      if (ctrl.shift) begin
        entry <= data_in;
      end
      if (ctrl.target_we) begin
        target <= ctrl.target_wdata;
      end
    end
  end

  always_comb begin
    diff       = $signed({1'b0, data_in}) - $signed({1'b0, target});
    low_bound  = -$signed({{(PULSE_W + 1 - TOL_W){1'b0}}, ctrl.tol_below});
    high_bound = $signed({{(PULSE_W + 1 - TOL_W){1'b0}}, ctrl.tol_above});
    hit        = (diff > low_bound) && (diff < high_bound);
  end

  assign data_out = entry;

endmodule

@@ design/pulse_sequence_matcher_core.sv @@
// Top level of the pulse sequence matcher: cell chain, repeat filter, result register.
// Depends on psm_pkg, psm_if and psm_cell.
//
// One pulse request is taken per clock, back to back, while no result waits unread;
// its result (accepted, match) appears in the output register in the cycle after
// acceptance, and the next request is taken in the same cycle the result is read.
// The five window cells check each entering width against their target in parallel
// within the accepting cycle. Register writes are taken at any time, one per cycle.
module pulse_sequence_matcher_core
  import psm_pkg::*;
(
  input logic       clk,
  input logic       rst,
  psm_pulse_if.sink   pulses,
  psm_result_if.source results,
  psm_cfg_if.sink     cfg
);

  pulse_t              previous_pulse;
  logic [FILL_W-1:0]   fill_count;
  tol_t                tol_below;
  tol_t                tol_above;
  logic                out_valid;
  logic                out_accepted;
  logic                out_match;

  logic                accept;
  logic                shift;
  logic                cfg_we;
  pulse_t              chain [WINDOW+1];
  logic [WINDOW-1:0]   hits;
  psm_cell_ctrl_t      ctrl [WINDOW];

  assign pulses.ready = !out_valid || results.ready;
  assign accept       = pulses.valid && pulses.ready;
  assign shift        = accept && (pulses.pulse_us != previous_pulse);
  assign cfg.ready    = 1'b1;
  assign cfg_we       = cfg.valid && cfg.ready;
  assign chain[WINDOW] = pulses.pulse_us;

  genvar g;
  generate
    for (g = 0; g < WINDOW; g++) begin : g_cell
      always_comb begin
        ctrl[g].shift        = shift;
        ctrl[g].target_we    = cfg_we && (cfg.index == CFG_IDX_W'(g));
        ctrl[g].target_wdata = cfg.data[PULSE_W-1:0];
        ctrl[g].tol_below    = tol_below;
        ctrl[g].tol_above    = tol_above;
      end
      psm_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl[g]),
        .target_init(TARGET_INIT[g]),
        .data_in    (chain[g+1]),
        .data_out   (chain[g]),
        .hit        (hits[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_pulse <= '0;
      fill_count     <= '0;
      tol_below      <= TOL_BELOW_INIT;
      tol_above      <= TOL_ABOVE_INIT;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we && (cfg.index == REG_TOL_BELOW)) begin
        tol_below <= cfg.data[TOL_W-1:0];
      end
      if (cfg_we && (cfg.index == REG_TOL_ABOVE)) begin
        tol_above <= cfg.data[TOL_W-1:0];
      end
      if (accept) begin
        previous_pulse <= pulses.pulse_us;
        out_valid      <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (shift && (fill_count < FILL_W'(WINDOW))) begin
        fill_count <= fill_count + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_accepted <= shift;
      out_match    <= shift && (fill_count >= FILL_W'(WINDOW - 1)) && (&hits);
    end
  end

  assign results.valid    = out_valid;
  assign results.accepted = out_accepted;
  assign results.match    = out_match;

endmodule
